[hw/rtl/hsv_pkg.sv]
// Types and constants shared by the host string validator modules.
package hsv_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned TOTAL_W = 9;
   localparam int unsigned LABEL_W = 7;
   localparam int unsigned OCTET_W = 9;
   localparam int unsigned PROD_W  = 13;   // holds 511 * 10 + 9

   localparam logic [TOTAL_W-1:0] MAX_NAME  = TOTAL_W'(253);
   localparam logic [LABEL_W-1:0] MAX_LABEL = LABEL_W'(63);
   localparam logic [OCTET_W-1:0] MAX_OCTET = OCTET_W'(255);

   // result kinds
   localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_IPV4     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_IPV6     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_HOSTNAME = 2'd3;

   // class of the previous hostname character
   localparam logic [1:0] PC_START  = 2'd0;
   localparam logic [1:0] PC_WORD   = 2'd1;
   localparam logic [1:0] PC_HYPHEN = 2'd2;
   localparam logic [1:0] PC_DOT    = 2'd3;

   typedef struct packed {
      logic       ws;
      logic       digit;
      logic       alpha;
      logic       dot;
      logic       hyphen;
      logic       colon;
      logic [3:0] digit_val;
   } hsv_class_type;

   typedef struct packed {
      logic               started;
      logic               pending_space;
      logic               only_digits_dots;
      logic               saw_colon;
      logic               name_bad;
      logic               quad_bad;
      logic [TOTAL_W-1:0] total_length;
      logic [LABEL_W-1:0] label_length;
      logic [1:0]         prev_class;
      logic [OCTET_W-1:0] octet_value;
      logic [1:0]         octet_digits;
      logic               octet_lead_zero;
      logic [2:0]         dot_count;
   } hsv_state_type;

   typedef struct packed {
      logic              valid_res;
      logic [KIND_W-1:0] kind;
   } hsv_verdict_type;

   localparam hsv_state_type ST_RESET = '{
      started:          1'b0,
      pending_space:    1'b0,
      only_digits_dots: 1'b1,
      saw_colon:        1'b0,
      name_bad:         1'b0,
      quad_bad:         1'b0,
      total_length:     '0,
      label_length:     '0,
      prev_class:       PC_START,
      octet_value:      '0,
      octet_digits:     2'd0,
      octet_lead_zero:  1'b0,
      dot_count:        3'd0
   };

endpackage

[hw/rtl/hsv_req_if.sv]
// Request channel: one character word with its end-of-string flag.
interface hsv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

[hw/rtl/hsv_rsp_if.sv]
// Response channel: one verdict word per string.
interface hsv_rsp_if;
   logic       valid;
   logic       ready;
   logic       valid_res;
   logic [1:0] kind;

   modport source (output valid, output valid_res, output kind, input ready);
   modport sink   (input valid, input valid_res, input kind, output ready);
endinterface

[hw/rtl/hsv_char_class.sv]
// Character classifier for Latin-1 codes.
module hsv_char_class (
   input  logic [hsv_pkg::CHAR_W-1:0] ch,
   output hsv_pkg::hsv_class_type     cls
);
   import hsv_pkg::*;

   logic [CHAR_W-1:0] diff;

   assign diff = ch - CHAR_W'(8'h30);

   always_comb begin
      cls.ws        = ch inside {[8'd9:8'd13], 8'd32, 8'h85, 8'hA0};
      cls.digit     = ch inside {[8'h30:8'h39]};
      cls.alpha     = ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
      cls.dot       = (ch == 8'h2E);
      cls.hyphen    = (ch == 8'h2D);
      cls.colon     = (ch == 8'h3A);
      cls.digit_val = diff[3:0];
   end
endmodule

[hw/rtl/hsv_state_core.sv]
// Per-string state registers, their update for one character and the verdict.
module hsv_state_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic                     last,
   input  hsv_pkg::hsv_class_type   cls,
   output hsv_pkg::hsv_verdict_type verdict
);
   import hsv_pkg::*;

   hsv_state_type st_ff, st_in, pre;
   logic [PROD_W-1:0]  prod;
   logic [LABEL_W-1:0] lab_inc;
   logic [2:0]         dots_inc;

   always_comb begin
      // inner whitespace penalty first
      pre = st_ff;
      if (cls.ws) begin
         if (st_ff.started) pre.pending_space = 1'b1;
      end else if (st_ff.pending_space) begin
         pre.name_bad         = 1'b1;
         pre.quad_bad         = 1'b1;
         pre.only_digits_dots = 1'b0;
         pre.pending_space    = 1'b0;
      end

      st_in    = pre;
      prod     = (PROD_W'(pre.octet_value) << 3) + (PROD_W'(pre.octet_value) << 1)
                 + PROD_W'(cls.digit_val);
      lab_inc  = (pre.label_length == '1) ? pre.label_length : pre.label_length + 1'b1;
      dots_inc = (pre.dot_count == 3'd7) ? pre.dot_count : pre.dot_count + 3'd1;

      if (!cls.ws) begin
         st_in.started = 1'b1;
         if (pre.total_length != '1) st_in.total_length = pre.total_length + 1'b1;
         if (cls.colon) st_in.saw_colon = 1'b1;
         if (!cls.digit && !cls.dot) st_in.only_digits_dots = 1'b0;

         // hostname rules
         if (cls.dot) begin
            if (pre.prev_class != PC_WORD) st_in.name_bad = 1'b1;
            st_in.label_length = '0;
            st_in.prev_class   = PC_DOT;
         end else begin
            if (cls.hyphen) begin
               if (pre.prev_class == PC_START || pre.prev_class == PC_DOT)
                  st_in.name_bad = 1'b1;
               st_in.prev_class = PC_HYPHEN;
            end else begin
               if (!cls.digit && !cls.alpha) st_in.name_bad = 1'b1;
               st_in.prev_class = PC_WORD;
            end
            st_in.label_length = lab_inc;
            if (lab_inc > MAX_LABEL) st_in.name_bad = 1'b1;
         end

         // dotted quad rules
         if (cls.digit) begin
            if (pre.octet_digits == 2'd0) begin
               st_in.octet_lead_zero = (cls.digit_val == 4'd0);
               st_in.octet_value     = OCTET_W'(cls.digit_val);
               st_in.octet_digits    = 2'd1;
            end else begin
               if (pre.octet_lead_zero || pre.octet_digits == 2'd3) st_in.quad_bad = 1'b1;
               if (pre.octet_digits != 2'd3) st_in.octet_digits = pre.octet_digits + 2'd1;
               st_in.octet_value = (prod > PROD_W'(511)) ? '1 : prod[OCTET_W-1:0];
            end
            if (st_in.octet_value > MAX_OCTET) st_in.quad_bad = 1'b1;
         end else if (cls.dot) begin
            if (pre.octet_digits == 2'd0 || pre.octet_value > MAX_OCTET)
               st_in.quad_bad = 1'b1;
            st_in.dot_count = dots_inc;
            if (dots_inc > 3'd3) st_in.quad_bad = 1'b1;
            st_in.octet_value     = '0;
            st_in.octet_digits    = 2'd0;
            st_in.octet_lead_zero = 1'b0;
         end
      end

      // verdict from the updated state
      if (!st_in.started) begin
         verdict.kind      = KIND_EMPTY;
         verdict.valid_res = 1'b0;
      end else if (st_in.only_digits_dots) begin
         verdict.kind      = KIND_IPV4;
         verdict.valid_res = !st_in.quad_bad && (st_in.octet_digits != 2'd0)
                             && (st_in.octet_value <= MAX_OCTET)
                             && (st_in.dot_count == 3'd3);
      end else if (st_in.saw_colon) begin
         verdict.kind      = KIND_IPV6;
         verdict.valid_res = 1'b0;
      end else begin
         verdict.kind      = KIND_HOSTNAME;
         verdict.valid_res = !st_in.name_bad && (st_in.prev_class == PC_WORD)
                             && (st_in.total_length <= MAX_NAME);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_RESET;
      end else if (step_en) begin
         st_ff <= last ? ST_RESET : st_in;
      end
   end
endmodule

[hw/rtl/host_string_validator_unit.sv]
// Top level of the host string validator: input register, checker core, result register.
//
//   channel   dir   word                        when
//   req_chan  in    ch[7:0], last               one per character
//   rsp_chan  out   valid_res, kind[1:0]        one per string, after the last char
//
// One character per cycle, apart from the final-character stall below. A word is held
// in the input register; a final character moves its verdict into the result register.
// Reset is synchronous and clears both valid flags and all string state.
// While a verdict waits in the result register, non-final characters still
// flow; only a final character stalls until the result register frees up.
module host_string_validator_unit (
   input logic       clock,
   input logic       reset,
   hsv_req_if.sink   req_chan,
   hsv_rsp_if.source rsp_chan
);
   import hsv_pkg::*;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0] s1_ch_ff;
   logic              s1_last_ff;
   logic              s1_adv;
   logic              req_take;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic              valid_res_ff;
   logic [KIND_W-1:0] kind_ff;

   hsv_class_type     cls;
   hsv_verdict_type   verdict;

   // a final char needs room in the result register; other chars always move
   assign s1_adv   = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_take = req_chan.valid && req_chan.ready;
   assign s1_valid_in = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ch_ff   <= req_chan.ch;
         s1_last_ff <= req_chan.last;
      end
   end

   hsv_char_class u_class (
      .ch  (s1_ch_ff),
      .cls (cls)
   );

   hsv_state_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (s1_adv),
      .last    (s1_last_ff),
      .cls     (cls),
      .verdict (verdict)
   );

   // result register loads on a final char, drains on ready
   assign out_valid_in = (s1_adv && s1_last_ff) ? 1'b1
                       : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_last_ff) begin
         valid_res_ff <= verdict.valid_res;
         kind_ff      <= verdict.kind;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.valid_res = valid_res_ff;
   assign rsp_chan.kind      = kind_ff;

   // a final char never overwrites a verdict that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(s1_adv && s1_last_ff && out_valid_ff && !rsp_chan.ready))
      else $error("verdict overwritten while stalled");

   // ipv6 forms and empty strings are never reported valid
   a_kind_verdict: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (kind_ff == KIND_IPV6 || kind_ff == KIND_EMPTY) |-> !valid_res_ff)
      else $error("valid verdict on an unjudged kind");

   // a verdict appears only after a final char left the input register
   a_verdict_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_adv && s1_last_ff))
      else $error("verdict without a final character");

   // nothing is shown right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !out_valid_ff && !s1_valid_ff)
      else $error("valid flags not cleared by reset");
endmodule

[bench/host_string_validator_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the host string validator unit, strings scored by a local predictor.
module host_string_validator_unit_tb;
   import hsv_pkg::*;

   // ---------------------------------------------------------------
   // Clock, reset, channels, block under test
   // ---------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   hsv_req_if req_chan ();
   hsv_rsp_if rsp_chan ();

   host_string_validator_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // ---------------------------------------------------------------
   // Constants
   // ---------------------------------------------------------------
   localparam int RANDOM_WORDS  = 590;   // random part stops once this many words are queued
   localparam int IDLE_LIMIT    = 2000;  // cycles with no word moving on either side
   localparam int DRAIN_CYCLES  = 8;     // the input and result registers, with margin
   localparam int HOLD_TRIGGER  = 400;   // words accepted before the long receiver hold
   localparam int HOLD_CYCLES   = 200;
   localparam int REPORT_LIMIT  = 10;

   localparam bit [7:0] CH_ZERO   = "0";
   localparam bit [7:0] CH_NINE   = "9";
   localparam bit [7:0] CH_UP_A   = "A";
   localparam bit [7:0] CH_UP_Z   = "Z";
   localparam bit [7:0] CH_LO_A   = "a";
   localparam bit [7:0] CH_LO_Z   = "z";
   localparam bit [7:0] CH_DOT    = ".";
   localparam bit [7:0] CH_HYPHEN = "-";
   localparam bit [7:0] CH_COLON  = ":";

   // every code the block treats as whitespace
   localparam bit [7:0] BLANKS [8] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32, 8'h85, 8'hA0};
   localparam string    ALNUM     =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
   localparam string    HEXDIGITS = "0123456789abcdefABCDEF";

   typedef struct packed {
      bit [7:0] ch;
      bit       last;
   } host_word_type;

   typedef enum int {RX_OPEN, RX_SKIP, RX_COIN, RX_SPARSE} rx_mode_type;

   // ---------------------------------------------------------------
   // Shared bench state
   // ---------------------------------------------------------------
   host_word_type   words_queued [$];   // words not yet accepted by the block
   hsv_verdict_type verdicts_due [$];   // predicted verdicts, oldest first
   bit [7:0]        text [$];           // string under construction
   hsv_state_type   host_st = ST_RESET; // predictor copy of the string state

   int words_taken   = 0;
   int verdicts_seen = 0;
   int fault_count   = 0;

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------
   function automatic bit is_blank(bit [7:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'h85 || c == 8'hA0;
   endfunction

   // Folds one non-blank character into the hostname and dotted-quad trackers.
   function automatic void fold_host_char(bit [7:0] c);
      bit          digit;
      bit          alpha;
      int unsigned prod;
      digit = (c >= CH_ZERO && c <= CH_NINE);
      alpha = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);

      if (host_st.total_length != '1) host_st.total_length += 1'b1;
      if (c == CH_COLON) host_st.saw_colon = 1'b1;
      if (!digit && c != CH_DOT) host_st.only_digits_dots = 1'b0;

      // hostname side: label lengths and character classes
      if (c == CH_DOT) begin
         if (host_st.prev_class != PC_WORD) host_st.name_bad = 1'b1;
         host_st.label_length = '0;
         host_st.prev_class   = PC_DOT;
      end else begin
         if (c == CH_HYPHEN) begin
            if (host_st.prev_class == PC_START || host_st.prev_class == PC_DOT)
               host_st.name_bad = 1'b1;
            host_st.prev_class = PC_HYPHEN;
         end else begin
            if (!digit && !alpha) host_st.name_bad = 1'b1;
            host_st.prev_class = PC_WORD;
         end
         if (host_st.label_length != '1) host_st.label_length += 1'b1;
         if (host_st.label_length > MAX_LABEL) host_st.name_bad = 1'b1;
      end

      // dotted-quad side: octet value, digit count, leading zero, dots
      if (digit) begin
         if (host_st.octet_digits == 2'd0) begin
            host_st.octet_lead_zero = (c == CH_ZERO);
            host_st.octet_value     = OCTET_W'(c - CH_ZERO);
            host_st.octet_digits    = 2'd1;
         end else begin
            if (host_st.octet_lead_zero || host_st.octet_digits >= 2'd3)
               host_st.quad_bad = 1'b1;
            if (host_st.octet_digits < 2'd3) host_st.octet_digits += 2'd1;
            prod = host_st.octet_value * 10 + (c - CH_ZERO);
            host_st.octet_value = (prod > 511) ? '1 : OCTET_W'(prod);
         end
         if (host_st.octet_value > MAX_OCTET) host_st.quad_bad = 1'b1;
      end else if (c == CH_DOT) begin
         if (host_st.octet_digits == 2'd0 || host_st.octet_value > MAX_OCTET)
            host_st.quad_bad = 1'b1;
         if (host_st.dot_count != '1) host_st.dot_count += 3'd1;
         if (host_st.dot_count > 3'd3) host_st.quad_bad = 1'b1;
         host_st.octet_value     = '0;
         host_st.octet_digits    = 2'd0;
         host_st.octet_lead_zero = 1'b0;
      end
   endfunction

   // One accepted word; on the final one the verdict is queued and the state cleared.
   function automatic void judge_host_byte(bit [7:0] c, bit fin);
      hsv_verdict_type v;
      if (is_blank(c)) begin
         if (host_st.started) host_st.pending_space = 1'b1;
      end else begin
         // blank run followed by more text: inner whitespace
         if (host_st.pending_space) begin
            host_st.name_bad         = 1'b1;
            host_st.quad_bad         = 1'b1;
            host_st.only_digits_dots = 1'b0;
            host_st.pending_space    = 1'b0;
         end
         host_st.started = 1'b1;
         fold_host_char(c);
      end
      if (fin) begin
         v.valid_res = 1'b0;
         if (!host_st.started) begin
            v.kind = KIND_EMPTY;
         end else if (host_st.only_digits_dots) begin
            v.kind      = KIND_IPV4;
            v.valid_res = !host_st.quad_bad && host_st.octet_digits != 2'd0 &&
                          host_st.octet_value <= MAX_OCTET && host_st.dot_count == 3'd3;
         end else if (host_st.saw_colon) begin
            v.kind = KIND_IPV6;        // never judged valid
         end else begin
            v.kind      = KIND_HOSTNAME;
            v.valid_res = !host_st.name_bad && host_st.prev_class == PC_WORD &&
                          host_st.total_length <= MAX_NAME;
         end
         verdicts_due.push_back(v);
         host_st = ST_RESET;
      end
   endfunction

   // ---------------------------------------------------------------
   // String builders
   // ---------------------------------------------------------------
   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endfunction

   function automatic void add_blank();
      text.push_back(BLANKS[$urandom_range(0, 7)]);
   endfunction

   // Label of letters and digits, with hyphens only inside.
   function automatic void add_label(int len);
      for (int i = 0; i < len; i++) begin
         if (i == 0 || i == len - 1 || $urandom_range(0, 9) != 0)
            text.push_back(ALNUM[$urandom_range(0, ALNUM.len() - 1)]);
         else
            text.push_back(CH_HYPHEN);
      end
   endfunction

   // Mostly four octets; some leading zeros, oversize or empty octets, wrong dot counts.
   function automatic void build_quad();
      int parts;
      int roll;
      roll  = $urandom_range(0, 9);
      parts = (roll < 7) ? 4 : (roll < 8) ? 3 : $urandom_range(5, 9);
      for (int i = 0; i < parts; i++) begin
         if (i > 0) add_text(".");
         roll = $urandom_range(0, 19);
         if (roll < 16)
            add_text($sformatf("%0d", $urandom_range(0, 255)));
         else if (roll < 17)
            add_text($sformatf("0%0d", $urandom_range(0, 99)));
         else if (roll < 19)
            add_text($sformatf("%0d", $urandom_range(256, 9999999)));
         // otherwise the octet stays empty
      end
   endfunction

   function automatic void build_hostname();
      int labels;
      int roll;
      int len;
      labels = $urandom_range(1, 5);
      if ($urandom_range(0, 19) == 0) add_text(".");
      for (int i = 0; i < labels; i++) begin
         if (i > 0) begin
            add_text(".");
            if ($urandom_range(0, 24) == 0) add_text(".");
         end
         roll = $urandom_range(0, 99);
         len  = (roll < 85) ? $urandom_range(1, 10) :
                (roll < 95) ? $urandom_range(11, 63) : $urandom_range(60, 130);
         if ($urandom_range(0, 29) == 0) add_text("-");
         add_label(len);
         if ($urandom_range(0, 29) == 0) add_text("-");
      end
      if ($urandom_range(0, 9) == 0) add_text(".");
   endfunction

   // Moves the built string into the word queue, last flag on its final byte.
   function automatic void queue_string();
      host_word_type w;
      if (text.size() == 0) add_blank();
      for (int i = 0; i < text.size(); i++) begin
         w.ch   = text[i];
         w.last = (i == text.size() - 1);
         words_queued.push_back(w);
      end
      text.delete();
   endfunction

   // ---------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------
   initial begin
      int random_words;
      int pick;
      int target;

      // directed: dotted quads
      add_text("192.168.0.1");      queue_string();
      add_text("255.255.255.255");  queue_string();
      add_text("0.0.0.0");          queue_string();
      add_text("256.1.1.1");        queue_string();
      add_text("01.2.3.4");         queue_string();
      add_text("1.2.3");            queue_string();
      add_text("1.2.3.4.5.6.7.8.9"); queue_string();   // dot count saturates
      add_text("1..2.3");           queue_string();
      add_text("1.2.3.4.");         queue_string();
      add_text("99999999.1.1.1");   queue_string();    // octet value saturates
      // surrounding whitespace is trimmed, inner whitespace is not
      add_text("  10.0.0.1\t"); text.push_back(8'hA0); queue_string();
      add_text("10.0 .0.1");        queue_string();
      // ipv6 forms
      add_text("::1");              queue_string();
      add_text("fe80::a:B");        queue_string();
      // hostnames
      add_text("example.com");      queue_string();
      add_text("A-9.b");            queue_string();
      add_text("-ab.com");          queue_string();
      add_text("ab-.com");          queue_string();
      add_text("a..b");             queue_string();
      add_text(".abc");             queue_string();
      add_text("user@host/x y");    queue_string();
      add_text("caf"); text.push_back(8'hE9); queue_string();  // non-ASCII letter
      // empty after trimming
      add_text(" ");                queue_string();
      text.push_back(8'h85); add_text("\t\r"); queue_string();
      // 253 characters with 63-character labels: the longest legal name
      add_label(63); add_text("."); add_label(63); add_text(".");
      add_label(63); add_text("."); add_label(61); queue_string();
      // label and total length counters both saturate
      add_label(130);
      repeat (6) begin
         add_text(".");
         add_label(63);
      end
      queue_string();

      // random strings
      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         if ($urandom_range(0, 4) == 0) add_blank();
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            build_quad();
         end else if (pick < 62) begin
            build_hostname();
         end else if (pick < 68) begin
            for (int i = 0; i < $urandom_range(2, 8); i++) begin
               if (i > 0) add_text(":");
               repeat ($urandom_range(0, 4))
                  text.push_back(HEXDIGITS[$urandom_range(0, HEXDIGITS.len() - 1)]);
            end
            if ($urandom_range(0, 3) == 0) add_text(".1.2.3");
         end else if (pick < 72) begin
            build_hostname();     // name with a port number
            add_text($sformatf(":%0d", $urandom_range(0, 65535)));
         end else if (pick < 82) begin
            repeat ($urandom_range(1, 16)) text.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 87) begin
            repeat ($urandom_range(1, 4)) add_blank();
         end else if (pick < 95) begin
            if ($urandom_range(0, 1) == 0) build_quad(); else build_hostname();
            repeat ($urandom_range(1, 3)) add_blank();
            if ($urandom_range(0, 1) == 0) build_quad(); else build_hostname();
         end else if (pick < 98) begin
            // long names near the 253 limit
            target = $urandom_range(230, 270);
            while (text.size() < target) begin
               if (text.size() != 0) add_text(".");
               add_label($urandom_range(40, 63));
            end
         end else begin
            // a single random character, so the string is mostly one character long
            text.push_back(8'($urandom_range(0, 255)));
         end
         if (text.size() != 0 && $urandom_range(0, 11) == 0)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 4) == 0) add_blank();
         random_words += (text.size() == 0) ? 1 : text.size();
         queue_string();
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (words_queued.size() != 0 || req_chan.valid) @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("host_string_validator_unit_tb passed");
      else
         $display("host_string_validator_unit_tb failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // Driver: bursts of words with random gaps between them
   // ---------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.ch    <= '0;
         req_chan.last  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            judge_host_byte(req_chan.ch, req_chan.last);
            void'(words_queued.pop_front());
            words_taken++;
         end
         // one assignment to valid per edge; a word held back stays put
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0 || words_queued.size() == 0) begin
               req_chan.valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               req_chan.valid <= 1'b1;
               req_chan.ch    <= words_queued[0].ch;
               req_chan.last  <= words_queued[0].last;
               if (burst_left == 0) burst_left = $urandom_range(1, 24);
               burst_left--;
               // a third of the bursts run straight into the next one
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: switches among four stall patterns,
   // plus one long hold so the block backs up into its input
   // ---------------------------------------------------------------
   rx_mode_type rx_mode;
   int          rx_tick;
   int          hold_left;
   bit          long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_mode   = RX_OPEN;
         rx_tick   = 0;
         hold_left = 0;
      end else begin
         rx_tick++;
         if (rx_tick % 48 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
         if (!long_hold_done && words_taken >= HOLD_TRIGGER) begin
            hold_left      = HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:  rsp_chan.ready <= 1'b1;
               RX_SKIP:  rsp_chan.ready <= (rx_tick % 4 != 0);
               RX_COIN:  rsp_chan.ready <= 1'($urandom_range(0, 1));
               default:  rsp_chan.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: each verdict word against the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      hsv_verdict_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         verdicts_seen++;
         if (verdicts_due.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("%0t: verdict %0d with none pending: valid_res=%0b kind=%0d",
                        $realtime, verdicts_seen, rsp_chan.valid_res, rsp_chan.kind);
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_chan.valid_res !== want.valid_res || rsp_chan.kind !== want.kind) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: verdict %0d expected %0b/%0d, got %0b/%0d",
                           $realtime, verdicts_seen, want.valid_res, want.kind,
                           rsp_chan.valid_res, rsp_chan.kind);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: ends the run when no word moves for too long
   // ---------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("host_string_validator_unit_tb failed");
         $finish;
      end
   end

endmodule
